@@ design/sdsc_pkg.sv @@
// ----------------------------------------------------------------------------
// sdsc_pkg
// Shared constants and controller/datapath interface types for the
// steepest descent step controller.
// ----------------------------------------------------------------------------
package sdsc_pkg;

   localparam int ForceW  = 32;
   localparam int EnergyW = 48;
   localparam int StepW   = 32;
   localparam int ScaleW  = 48;
   localparam int IterW   = 24;
   localparam int SqW     = 64;
   localparam int FracGap = 24;                 // Q4.28 over Q20.12 into Q8.40
   localparam int DvdW    = StepW + FracGap;
   localparam int RootSteps = SqW / 2;
   localparam int RootCntW  = $clog2(RootSteps);
   localparam int DivCntW   = $clog2(DvdW);

   localparam logic [1:0] CSR_FORCE_TOL = 2'd0;
   localparam logic [1:0] CSR_INIT_STEP = 2'd1;
   localparam logic [1:0] CSR_MAX_ITER  = 2'd2;

   localparam logic [31:0]       RST_FORCE_TOL = 32'd40960;
   localparam logic [StepW-1:0]  RST_INIT_STEP = 32'd2684355;
   localparam logic [IterW-1:0]  RST_MAX_ITER  = 24'd0;

   localparam logic [StepW-1:0]  STEP_FLOOR = 32'd269;   // 1e-6 nm
   localparam logic [StepW-1:0]  RECIP5     = 32'hCCCCCCCD; // ceil(2^34/5)
   localparam int                RecipShift = 34;

   typedef struct packed {
      logic root_step;
      logic decide;
      logic grow_mul;
      logic grow_add;
      logic div_load;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic last_done;
      logic last_pending;
      logic root_last;
      logic div_last;
      logic grow_needed;
   } status_type;

endpackage

@@ design/sdsc_ctrl.sv @@
// ----------------------------------------------------------------------------
// sdsc_ctrl
// Sequencer: collect atoms, root, decision, step growth, division, response.
// ----------------------------------------------------------------------------
module sdsc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  sdsc_pkg::status_type st,
   input  logic                 rsp_ready,
   output logic                 req_ready,
   output logic                 rsp_valid,
   output sdsc_pkg::cmd_type    cmd
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_ROOT     = 3'd1;
   localparam logic [2:0] S_DECIDE   = 3'd2;
   localparam logic [2:0] S_GROW_MUL = 3'd3;
   localparam logic [2:0] S_GROW_ADD = 3'd4;
   localparam logic [2:0] S_DIV_LOAD = 3'd5;
   localparam logic [2:0] S_DIV      = 3'd6;
   localparam logic [2:0] S_FINISH   = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       resp_ff, resp_in;

   always_comb begin
      state_in = state_ff;
      resp_in  = resp_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (!resp_ff && st.last_done) state_in = S_ROOT;
            if (resp_ff && rsp_ready) resp_in = 1'b0;
         end
         S_ROOT: begin
            cmd.root_step = 1'b1;
            if (st.root_last) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            state_in = S_GROW_MUL;
         end
         S_GROW_MUL: begin
            // growth only after an accepted, non-first trial
            cmd.grow_mul = st.grow_needed;
            state_in = st.grow_needed ? S_GROW_ADD : S_DIV_LOAD;
         end
         S_GROW_ADD: begin
            cmd.grow_add = 1'b1;
            state_in = S_DIV_LOAD;
         end
         S_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (st.div_last) state_in = S_FINISH;
         end
         S_FINISH: begin
            cmd.out_load = 1'b1;
            resp_in  = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         resp_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         resp_ff  <= resp_in;
      end
   end

   assign rsp_valid = resp_ff && (state_ff == S_IDLE);
   assign req_ready = (state_ff == S_IDLE) && !resp_ff && !st.last_pending;

   a_no_req_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken while response pending");
   a_root_follows_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && !resp_ff && st.last_done) |=> state_ff == S_ROOT)
      else $error("iteration end did not start root");
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == S_FINISH)
      else $error("response raised outside finish");

endmodule

@@ design/sdsc_dp.sv @@
// ----------------------------------------------------------------------------
// sdsc_dp
// Datapath: square pipeline, running maximum, serial root, step update,
// serial divider, configuration and result registers.
// ----------------------------------------------------------------------------
module sdsc_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  sdsc_pkg::cmd_type    cmd,
   output sdsc_pkg::status_type st,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [31:0]          csr_wdata,
   input  logic                 req_take,
   input  logic signed [31:0]   req_force_x,
   input  logic signed [31:0]   req_force_y,
   input  logic signed [31:0]   req_force_z,
   input  logic [2:0]           req_freeze_mask,
   input  logic                 req_last_atom,
   input  logic signed [47:0]   req_potential_energy,
   output logic                 rsp_accepted,
   output logic                 rsp_converged,
   output logic                 rsp_aborted,
   output logic [31:0]          rsp_trial_max_force,
   output logic [47:0]          rsp_step_scale,
   output logic [23:0]          rsp_iteration
);

   logic [31:0] tol_ff;
   logic [31:0] init_ff;
   logic [23:0] maxit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff   <= sdsc_pkg::RST_FORCE_TOL;
         init_ff  <= sdsc_pkg::RST_INIT_STEP;
         maxit_ff <= sdsc_pkg::RST_MAX_ITER;
      end else if (csr_we) begin
         case (csr_index)
            sdsc_pkg::CSR_FORCE_TOL: tol_ff   <= csr_wdata;
            sdsc_pkg::CSR_INIT_STEP: init_ff  <= csr_wdata;
            sdsc_pkg::CSR_MAX_ITER:  maxit_ff <= csr_wdata[23:0];
            default: ;
         endcase
      end
   end

   // stage 1: masked magnitudes
   logic [31:0] mag_x, mag_y, mag_z;
   logic [31:0] mx_ff, my_ff, mz_ff;
   logic        v1_ff, l1_ff, v2_ff, l2_ff;
   logic [47:0] e1_ff, e2_ff;
   logic        halted_ff;

   always_comb begin
      mag_x = req_freeze_mask[0] ? 32'd0 :
              (req_force_x[31] ? 32'(~req_force_x + 32'd1) : 32'(req_force_x));
      mag_y = req_freeze_mask[1] ? 32'd0 :
              (req_force_y[31] ? 32'(~req_force_y + 32'd1) : 32'(req_force_y));
      mag_z = req_freeze_mask[2] ? 32'd0 :
              (req_force_z[31] ? 32'(~req_force_z + 32'd1) : 32'(req_force_z));
   end

   // stage 2: squares
   logic [63:0] sqx_ff, sqy_ff, sqz_ff;
   logic [63:0] sum, max_ff, max_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= req_take && !halted_ff;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      mx_ff  <= mag_x;
      my_ff  <= mag_y;
      mz_ff  <= mag_z;
      l1_ff  <= req_last_atom;
      e1_ff  <= req_potential_energy;
      sqx_ff <= 64'(mx_ff) * 64'(mx_ff);
      sqy_ff <= 64'(my_ff) * 64'(my_ff);
      sqz_ff <= 64'(mz_ff) * 64'(mz_ff);
      l2_ff  <= l1_ff;
      e2_ff  <= e1_ff;
   end

   assign sum      = sqx_ff + sqy_ff + sqz_ff;
   assign max_next = (v2_ff && sum > max_ff) ? sum : max_ff;

   // serial root, two radicand bits a cycle
   logic [63:0] rad_ff;
   logic [33:0] rem_ff, rem_sh, trial;
   logic [31:0] root_ff;
   logic [sdsc_pkg::RootCntW-1:0] rcnt_ff;
   logic [47:0] energy_ff;
   logic        last_done;

   assign last_done = v2_ff && l2_ff;
   assign rem_sh    = {rem_ff[31:0], rad_ff[63:62]};
   assign trial     = {root_ff, 2'b01};

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= '0;
      end else if (last_done) begin
         max_ff <= '0;
      end else begin
         max_ff <= max_next;
      end
   end

   always_ff @(posedge clock) begin
      if (last_done) begin
         rad_ff    <= max_next;
         rem_ff    <= '0;
         root_ff   <= '0;
         rcnt_ff   <= '0;
         energy_ff <= e2_ff;
      end else if (cmd.root_step) begin
         rad_ff  <= {rad_ff[61:0], 2'b00};
         rcnt_ff <= rcnt_ff + 1'b1;
         if (rem_sh >= trial) begin
            rem_ff  <= rem_sh - trial;
            root_ff <= {root_ff[30:0], 1'b1};
         end else begin
            rem_ff  <= rem_sh;
            root_ff <= {root_ff[30:0], 1'b0};
         end
      end
   end

   // decision, step update and divider
   logic [47:0] min_e_ff;
   logic [31:0] mmf_ff, step_ff, base;
   logic [23:0] iter_ff;
   logic        first, accept;
   logic        acc_ff, conv_ff, grow_ff, alim_ff;
   logic [63:0] prod_ff;
   logic [32:0] grown;
   logic [55:0] dvd_ff, quo_ff;
   logic [31:0] drem_ff;
   logic [32:0] drs, ddv;
   logic [sdsc_pkg::DivCntW-1:0] dcnt_ff;
   logic        abort_now;

   assign first  = (iter_ff == '0);
   assign accept = first || ($signed(energy_ff) < $signed(min_e_ff));
   assign base   = first ? init_ff : step_ff;
   // floor(6s/5) = s + floor(s/5)
   assign grown  = {1'b0, step_ff} + 33'(prod_ff[63:sdsc_pkg::RecipShift]);
   assign drs    = {drem_ff, dvd_ff[55]};
   assign ddv    = {1'b0, mmf_ff};
   assign abort_now = alim_ff || (step_ff < sdsc_pkg::STEP_FLOOR);

   always_ff @(posedge clock) begin
      if (reset) begin
         min_e_ff  <= '0;
         mmf_ff    <= '0;
         step_ff   <= sdsc_pkg::RST_INIT_STEP;
         iter_ff   <= '0;
         halted_ff <= 1'b0;
      end else begin
         if (cmd.decide) begin
            step_ff <= accept ? base : {1'b0, base[31:1]};
            if (accept) begin
               min_e_ff <= energy_ff;
               mmf_ff   <= root_ff;
            end
         end
         if (cmd.grow_add) step_ff <= grown[32] ? 32'hFFFFFFFF : grown[31:0];
         if (cmd.out_load) begin
            halted_ff <= conv_ff || abort_now;
            if (iter_ff != 24'hFFFFFF) iter_ff <= iter_ff + 24'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.decide) begin
         acc_ff  <= accept;
         conv_ff <= accept && (root_ff < tol_ff);
         grow_ff <= accept && !first;
         alim_ff <= (maxit_ff != '0) && (iter_ff == maxit_ff);
      end
      if (cmd.grow_mul) prod_ff <= 64'(step_ff) * 64'(sdsc_pkg::RECIP5);
      if (cmd.div_load) begin
         dvd_ff  <= {step_ff, 24'd0};
         drem_ff <= '0;
         quo_ff  <= '0;
         dcnt_ff <= '0;
      end else if (cmd.div_step) begin
         dvd_ff  <= {dvd_ff[54:0], 1'b0};
         dcnt_ff <= dcnt_ff + 1'b1;
         // zero divisor yields all ones, which saturates below
         if (drs >= ddv) begin
            drem_ff <= 32'(drs - ddv);
            quo_ff  <= {quo_ff[54:0], 1'b1};
         end else begin
            drem_ff <= drs[31:0];
            quo_ff  <= {quo_ff[54:0], 1'b0};
         end
      end
      if (cmd.out_load) begin
         rsp_accepted        <= acc_ff;
         rsp_converged       <= conv_ff;
         rsp_aborted         <= abort_now;
         rsp_trial_max_force <= root_ff;
         rsp_step_scale      <= (quo_ff[55:48] != '0) ? 48'hFFFFFFFFFFFF : quo_ff[47:0];
         rsp_iteration       <= iter_ff;
      end
   end

   assign st.last_done    = last_done;
   assign st.last_pending = (v1_ff && l1_ff) || (v2_ff && l2_ff);
   assign st.root_last    = (rcnt_ff == sdsc_pkg::RootCntW'(sdsc_pkg::RootSteps - 1));
   assign st.div_last     = (dcnt_ff == sdsc_pkg::DivCntW'(sdsc_pkg::DvdW - 1));
   assign st.grow_needed  = grow_ff;

   a_halt_blocks_pipe: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> !v1_ff) else $error("item entered pipe after halt");
   a_max_cleared: assert property (@(posedge clock) disable iff (reset)
      last_done |=> max_ff == '0) else $error("running max not cleared");
   a_grow_only_on_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.grow_add |-> acc_ff) else $error("step grown on rejection");

endmodule

@@ design/steepest_descent_step_control.sv @@
// ----------------------------------------------------------------------------
// steepest_descent_step_control
// Adaptive step control for steepest descent energy minimization.
// ----------------------------------------------------------------------------
// Atom requests stream in at one per cycle through a three-stage square and
// maximum pipeline. The request flagged last_atom closes the iteration: the
// block then stops taking requests while a serial root (two bits a cycle),
// the accept decision and step update, the divider load and a serial 56-bit
// divider (one quotient bit a cycle) run, and the single response is held
// until taken. After a converged or aborted response every request is taken
// and dropped until reset.
module steepest_descent_step_control (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_wdata,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic signed [31:0]  req_force_x,
   input  logic signed [31:0]  req_force_y,
   input  logic signed [31:0]  req_force_z,
   input  logic [2:0]          req_freeze_mask,
   input  logic                req_last_atom,
   input  logic signed [47:0]  req_potential_energy,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_accepted,
   output logic                rsp_converged,
   output logic                rsp_aborted,
   output logic [31:0]         rsp_trial_max_force,
   output logic [47:0]         rsp_step_scale,
   output logic [23:0]         rsp_iteration
);

   sdsc_pkg::cmd_type    cmd;
   sdsc_pkg::status_type st;

   sdsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .st        (st),
      .rsp_ready (rsp_ready),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   sdsc_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .st                   (st),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_take             (req_valid && req_ready),
      .req_force_x          (req_force_x),
      .req_force_y          (req_force_y),
      .req_force_z          (req_force_z),
      .req_freeze_mask      (req_freeze_mask),
      .req_last_atom        (req_last_atom),
      .req_potential_energy (req_potential_energy),
      .rsp_accepted         (rsp_accepted),
      .rsp_converged        (rsp_converged),
      .rsp_aborted          (rsp_aborted),
      .rsp_trial_max_force  (rsp_trial_max_force),
      .rsp_step_scale       (rsp_step_scale),
      .rsp_iteration        (rsp_iteration)
   );

endmodule
